[src/edt_pkg.sv]
package edt_pkg;
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int QDEPTH = 2;
  localparam logic [2:0] TOP_PRI_RESET = 3'd3;

  localparam logic [2:0] ST_RELEASED = 3'd0;
  localparam logic [2:0] ST_ONTIME = 3'd1;
  localparam logic [2:0] ST_OVERDUE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  localparam logic MODE_RELEASE = 1'b0;
  localparam logic MODE_COMPLETE = 1'b1;

  typedef struct packed {
    logic mode;
    logic [7:0] task_id;
    logic [15:0] relative_deadline;
    logic [15:0] handle;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [2:0] event_status;
    logic [15:0] assigned_handle;
    logic entry_valid;
    logic [15:0] entry_handle;
    logic [7:0] entry_task_id;
    logic [2:0] entry_priority;
    logic [4:0] live_count;
    logic [15:0] ontime_count;
    logic [15:0] late_count;
    logic last;
  } result_t;

  // Front-classified command handed to the table engine.
  typedef struct packed {
    logic mode;
    logic [7:0] task_id;
    logic [15:0] handle;
    logic [31:0] deadline;
    logic [31:0] now;
  } cmd_t;
endpackage

[src/edt_if.sv]
interface edt_item_if;
  import edt_pkg::*;
  logic valid;
  logic ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface edt_result_if;
  import edt_pkg::*;
  logic valid;
  logic ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface edt_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/edt_front.sv]
module edt_front (
  input  logic clk,
  input  logic rst,
  edt_item_if.sink in,
  output logic q_valid,
  input  logic q_ready,
  output edt_pkg::cmd_t q_cmd
);
  import edt_pkg::*;

  cmd_t fifo [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wr_ptr, rd_ptr;
  logic [$clog2(QDEPTH):0] fill;
  cmd_t cmd_in;
  logic push, pop;

  always_comb begin
    cmd_in.mode = in.data.mode;
    cmd_in.task_id = in.data.task_id;
    cmd_in.handle = in.data.handle;
    cmd_in.deadline = in.data.now + {16'd0, in.data.relative_deadline};
    cmd_in.now = in.data.now;
  end

  assign in.ready = (fill != QDEPTH[$clog2(QDEPTH):0]);
  assign push = in.valid && in.ready;
  assign q_valid = (fill != '0);
  assign pop = q_valid && q_ready;
  assign q_cmd = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wr_ptr] <= cmd_in;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + {{$clog2(QDEPTH){1'b0}}, push} - {{$clog2(QDEPTH){1'b0}}, pop};
    end
  end
endmodule

[src/edt_back.sv]
module edt_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  edt_pkg::cmd_t q_cmd,
  input  logic [2:0] top_priority,
  edt_result_if.source out,
  output logic busy
);
  import edt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} state_t;

  state_t state;
  logic [15:0] hnd [DEPTH];
  logic [7:0] ids [DEPTH];
  logic [31:0] dls [DEPTH];
  logic [CNT_W-1:0] occupancy;
  logic [15:0] next_handle, ontime_total, overdue_total;
  cmd_t cmd;
  logic [CNT_W-1:0] pos;
  logic [2:0] status;
  logic [15:0] assigned;
  logic [IDX_W-1:0] rank;
  logic [2:0] pri;
  logic [IDX_W-1:0] pidx;
  logic hit, at_end;

  assign pidx = pos[IDX_W-1:0];
  assign at_end = (pos == occupancy);
  assign hit = (cmd.mode == MODE_RELEASE) ? (dls[pidx] > cmd.deadline)
                                          : (hnd[pidx] == cmd.handle);
  assign q_ready = (state == S_IDLE);
  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      occupancy <= '0;
      next_handle <= '0;
      ontime_total <= '0;
      overdue_total <= '0;
      out.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            pos <= '0;
            assigned <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // One entry is compared per cycle; the shift is done in parallel at the end.
          if (cmd.mode == MODE_RELEASE && occupancy == DEPTH[CNT_W-1:0]) begin
            status <= ST_FULL;
            state <= S_EMIT;
          end else if (at_end || hit) begin
            if (cmd.mode == MODE_RELEASE) begin
              for (int i = DEPTH - 1; i > 0; i--) begin
                if (i > pos) begin
                  hnd[i] <= hnd[i-1];
                  ids[i] <= ids[i-1];
                  dls[i] <= dls[i-1];
                end
              end
              hnd[pidx] <= next_handle;
              ids[pidx] <= cmd.task_id;
              dls[pidx] <= cmd.deadline;
              assigned <= next_handle;
              next_handle <= next_handle + 16'd1;
              occupancy <= occupancy + 1'b1;
              status <= ST_RELEASED;
            end else if (at_end) begin
              status <= ST_NOT_FOUND;
            end else begin
              for (int i = 0; i < DEPTH - 1; i++) begin
                if (i >= pos) begin
                  hnd[i] <= hnd[i+1];
                  ids[i] <= ids[i+1];
                  dls[i] <= dls[i+1];
                end
              end
              occupancy <= occupancy - 1'b1;
              if (cmd.now > dls[pidx]) begin
                status <= ST_OVERDUE;
                if (overdue_total != 16'hFFFF) overdue_total <= overdue_total + 16'd1;
              end else begin
                status <= ST_ONTIME;
                if (ontime_total != 16'hFFFF) ontime_total <= ontime_total + 16'd1;
              end
            end
            state <= S_EMIT;
          end else begin
            pos <= pos + 1'b1;
          end
          rank <= '0;
          pri <= (top_priority == 3'd0) ? 3'd1 : top_priority;
        end
        S_EMIT: begin
          if (!out.valid || out.ready) begin
            out.valid <= 1'b1;
            out.data.event_status <= status;
            out.data.assigned_handle <= assigned;
            out.data.entry_valid <= (occupancy != '0);
            out.data.entry_handle <= (occupancy != '0) ? hnd[rank] : 16'd0;
            out.data.entry_task_id <= (occupancy != '0) ? ids[rank] : 8'd0;
            out.data.entry_priority <= (occupancy != '0) ? pri : 3'd0;
            out.data.live_count <= 5'(occupancy);
            out.data.ontime_count <= ontime_total;
            out.data.late_count <= overdue_total;
            if (occupancy == '0 || {1'b0, rank} == occupancy - 1'b1) begin
              out.data.last <= 1'b1;
              state <= S_IDLE;
            end else begin
              out.data.last <= 1'b0;
            end
            rank <= rank + 1'b1;
            if (pri > 3'd1) pri <= pri - 3'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (state != S_EMIT && out.valid && out.ready) out.valid <= 1'b0;
    end
  end
endmodule

[src/edf_deadline_table.sv]
// Channel   Dir   Payload
// in        sink  mode, task_id, relative_deadline, handle, now
// out       src   one beat per active entry (one beat when empty), last on final
// cfg       sink  top_priority, 3 bits
// An item is taken from the queue, located by walking the entries in order (one
// compare per cycle), and then emits its output beats; a release to a full table skips the walk.
// Reset is synchronous on rst; table contents are not cleared.
// A two-entry queue lets the front accept items while the back engine works;
// output stalls hold the engine in its emit state.
module edf_deadline_table (
  input logic clk,
  input logic rst,
  edt_item_if.sink in,
  edt_result_if.source out,
  edt_cfg_if.sink cfg
);
  import edt_pkg::*;

  logic q_valid, q_ready, busy;
  cmd_t q_cmd;
  logic [2:0] top_priority;

  // The priority register only changes while no item is queued or in the engine.
  assign cfg.ready = !busy && !q_valid;
  always_ff @(posedge clk) begin
    if (rst) top_priority <= TOP_PRI_RESET;
    else if (cfg.valid && cfg.ready) top_priority <= cfg.data;
  end

  edt_front u_front (.clk, .rst, .in, .q_valid, .q_ready, .q_cmd);
  edt_back u_back (.clk, .rst, .q_valid, .q_ready, .q_cmd, .top_priority, .out, .busy);

`ifndef SYNTHESIS
  a_pri_nonzero: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.data.entry_valid |-> out.data.entry_priority != 3'd0) else $error("pri");
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.data.entry_valid |-> out.data.last) else $error("empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out.valid |-> out.data.live_count <= 5'd16) else $error("count");
`endif
endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import edt_pkg::*;

  logic clk;
  logic rst;

  edt_item_if item_ch();
  edt_result_if res_ch();
  edt_cfg_if cfg_ch();

  edf_deadline_table dut (
    .clk(clk),
    .rst(rst),
    .in(item_ch),
    .out(res_ch),
    .cfg(cfg_ch)
  );

  localparam int IDLE_AFTER = 4 * DEPTH + 20;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_LEN = 400;

  typedef struct {
    bit typed;
    item_t it;
    result_t want;
  } row_t;

  // Shadow of the deadline table.
  logic [15:0] tbl_handle [DEPTH];
  logic [7:0] tbl_id [DEPTH];
  logic [31:0] tbl_deadline [DEPTH];
  int unsigned tbl_occ;
  logic [15:0] tbl_next_handle;
  logic [15:0] tbl_ontime;
  logic [15:0] tbl_overdue;
  logic [2:0] tbl_top_pri;

  result_t beat_q[$];
  row_t rows[$];
  int errors = 0;
  bit quiet;
  bit hold_req;
  int stall_cnt = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic add_row(input logic mode, input logic [7:0] tid, input logic [15:0] rel,
                         input logic [15:0] hnd, input logic [31:0] now, input bit typed,
                         input result_t want);
    row_t r;
    r.typed = typed;
    r.it = '{mode: mode, task_id: tid, relative_deadline: rel, handle: hnd, now: now};
    r.want = want;
    rows.push_back(r);
  endtask

  // Applies one item to the shadow table and queues the beats it produces.
  task automatic schedule_item(input item_t it, input bit typed, input result_t want);
    logic [2:0] st;
    logic [15:0] given;
    logic [31:0] dl;
    int unsigned pos;
    int unsigned n;
    int unsigned pri;
    result_t b;
    given = '0;
    if (it.mode == MODE_RELEASE) begin
      if (tbl_occ >= DEPTH) begin
        st = ST_FULL;
      end else begin
        dl = it.now + {16'd0, it.relative_deadline};
        pos = 0;
        while (pos < tbl_occ && tbl_deadline[pos] <= dl) pos++;
        for (int i = tbl_occ; i > pos; i--) begin
          tbl_handle[i] = tbl_handle[i-1];
          tbl_id[i] = tbl_id[i-1];
          tbl_deadline[i] = tbl_deadline[i-1];
        end
        given = tbl_next_handle;
        tbl_handle[pos] = given;
        tbl_id[pos] = it.task_id;
        tbl_deadline[pos] = dl;
        tbl_next_handle++;
        tbl_occ++;
        st = ST_RELEASED;
      end
    end else begin
      pos = 0;
      while (pos < tbl_occ && tbl_handle[pos] != it.handle) pos++;
      if (pos >= tbl_occ) begin
        st = ST_NOT_FOUND;
      end else begin
        dl = tbl_deadline[pos];
        for (int i = pos; i + 1 < tbl_occ; i++) begin
          tbl_handle[i] = tbl_handle[i+1];
          tbl_id[i] = tbl_id[i+1];
          tbl_deadline[i] = tbl_deadline[i+1];
        end
        tbl_occ--;
        if (it.now > dl) begin
          st = ST_OVERDUE;
          if (tbl_overdue != 16'hFFFF) tbl_overdue++;
        end else begin
          st = ST_ONTIME;
          if (tbl_ontime != 16'hFFFF) tbl_ontime++;
        end
      end
    end
    if (typed) begin
      beat_q.push_back(want);
    end else begin
      n = (tbl_occ == 0) ? 1 : tbl_occ;
      pri = (tbl_top_pri == 0) ? 1 : tbl_top_pri;
      for (int k = 0; k < n; k++) begin
        b.event_status = st;
        b.assigned_handle = given;
        b.entry_valid = (tbl_occ != 0);
        b.entry_handle = b.entry_valid ? tbl_handle[k] : 16'd0;
        b.entry_task_id = b.entry_valid ? tbl_id[k] : 8'd0;
        b.entry_priority = b.entry_valid ? 3'(pri) : 3'd0;
        b.live_count = 5'(tbl_occ);
        b.ontime_count = tbl_ontime;
        b.late_count = tbl_overdue;
        b.last = (k + 1 == n);
        beat_q.push_back(b);
        if (pri > 1) pri--;
      end
    end
  endtask

  // Called at a clock edge; returns at the edge where the item is accepted.
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data <= it;
    do @(posedge clk); while (!item_ch.ready);
    schedule_item(it, typed, want);
  endtask

  task automatic write_priority(input logic [2:0] v);
    item_ch.valid <= 1'b0;
    while (beat_q.size() != 0) @(posedge clk);
    repeat (IDLE_AFTER) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    tbl_top_pri = v;
  endtask

  function automatic item_t random_item();
    item_t it;
    int unsigned r;
    int unsigned k;
    it.mode = MODE_RELEASE;
    it.task_id = 8'($urandom);
    it.relative_deadline = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 8))
                                                       : 16'($urandom);
    it.handle = 16'($urandom);
    it.now = $urandom;
    r = $urandom_range(0, 9);
    if (r >= 5) begin
      it.mode = MODE_COMPLETE;
      if (r < 9 && tbl_occ > 0) begin
        k = $urandom_range(0, tbl_occ - 1);
        it.handle = tbl_handle[k];
        // Finish around the deadline to hit both sides of the compare.
        if ($urandom_range(0, 1) == 0)
          it.now = tbl_deadline[k] + 32'($signed($urandom_range(0, 4)) - 2);
      end
    end
    return it;
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $display("%0t %s expected %0h actual %0h", $realtime, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (beat_q.size() == 0) begin
        $display("%0t unexpected beat expected none actual %h", $realtime, res_ch.data);
        errors++;
      end else begin
        result_t w;
        w = beat_q.pop_front();
        check_field("event_status", w.event_status, res_ch.data.event_status);
        check_field("assigned_handle", w.assigned_handle, res_ch.data.assigned_handle);
        check_field("entry_valid", w.entry_valid, res_ch.data.entry_valid);
        check_field("entry_handle", w.entry_handle, res_ch.data.entry_handle);
        check_field("entry_task_id", w.entry_task_id, res_ch.data.entry_task_id);
        check_field("entry_priority", w.entry_priority, res_ch.data.entry_priority);
        check_field("live_count", w.live_count, res_ch.data.live_count);
        check_field("ontime_count", w.ontime_count, res_ch.data.ontime_count);
        check_field("late_count", w.late_count, res_ch.data.late_count);
        check_field("last", w.last, res_ch.data.last);
      end
    end
  end

  // Result side: random back-pressure plus one long hold-off on request.
  initial begin
    bit held;
    held = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("edf_deadline_table: mismatch");
        $finish;
      end
    end
  end

  initial begin
    result_t none;
    result_t w;
    none = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    tbl_occ = 0;
    tbl_next_handle = '0;
    tbl_ontime = '0;
    tbl_overdue = '0;
    tbl_top_pri = TOP_PRI_RESET;
    item_ch.valid = 1'b0;
    item_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Completion on an empty table, then a release whose deadline wraps.
    w = '{event_status: ST_NOT_FOUND, last: 1'b1, default: '0};
    add_row(MODE_COMPLETE, 8'h00, 16'h0000, 16'h0005, 32'h0, 1'b1, w);
    w = '{event_status: ST_RELEASED, entry_valid: 1'b1, entry_task_id: 8'hFF,
          entry_priority: 3'd3, live_count: 5'd1, last: 1'b1, default: '0};
    add_row(MODE_RELEASE, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, w);
    // Equal deadlines go after each other.
    add_row(MODE_RELEASE, 8'h00, 16'h0000, 16'h0000, 32'h0, 1'b0, none);
    add_row(MODE_RELEASE, 8'h01, 16'h0000, 16'hFFFF, 32'h0, 1'b0, none);
    for (int i = 0; i < 13; i++)
      add_row(MODE_RELEASE, 8'(8'h10 + i), 16'(i * 5003), 16'h0, 32'(i * 77), 1'b0, none);
    // Seventeenth release finds the table full.
    add_row(MODE_RELEASE, 8'hAA, 16'h0001, 16'h0, 32'h1234_5678, 1'b0, none);
    add_row(MODE_COMPLETE, 8'h00, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 1'b0, none);
    add_row(MODE_COMPLETE, 8'h00, 16'h0000, 16'h0001, 32'h0, 1'b0, none);
    add_row(MODE_COMPLETE, 8'hFF, 16'hFFFF, 16'h0009, 32'h5, 1'b0, none);
    add_row(MODE_COMPLETE, 8'h00, 16'h0000, 16'hFFFF, 32'h0, 1'b0, none);
    add_row(MODE_RELEASE, 8'h5A, 16'h8000, 16'h0, 32'h8000_0000, 1'b0, none);
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_priority(3'd7);
        1: write_priority(3'd1);
        2: write_priority(3'd0);
        3: write_priority(3'($urandom_range(2, 6)));
        default: begin
          write_priority(3'd7);
          quiet = 1'b1;
        end
      endcase
      // The long hold-off lets the block fill up while items keep coming.
      if (ph == 1) hold_req = 1'b1;
      for (int n = 0; n < 38; n++) send_item(random_item(), 1'b0, none);
    end
    item_ch.valid <= 1'b0;

    while (beat_q.size() != 0) @(posedge clk);
    repeat (IDLE_AFTER) @(posedge clk);
    if (errors == 0 && beat_q.size() == 0) begin
      $display("edf_deadline_table: match");
    end else begin
      $display("edf_deadline_table: mismatch");
    end
    $finish;
  end

endmodule
